@@ rtl/rss_pkg.sv @@
// Shared types for the ranked sorted set: input and result beats, command
// codes and the control bundle driven from the top level into every cell.
// No dependencies.
package rss_pkg;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdRemove = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] key;
    logic        [5:0]  rank;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] position;
    logic       rejected;
  } out_beat_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

@@ rtl/rss_cell.sv @@
// One slot of the sorted chain: holds a key, compares it with the operand
// and shifts toward or away from its neighbors on insert and remove.
// Depends on rss_pkg.
module rss_cell
  import rss_pkg::*;
#(
  parameter int CNT_W    = 7,
  parameter int KEY_BITS = 32,
  parameter int INDEX    = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [CNT_W-1:0]    rank_i,
  input  logic [KEY_BITS-1:0] op_key_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic                left_gt_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic                gt_o
);

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(INDEX);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                gt_q, gt_d;
  logic                valid;

  assign valid = IdxC < count_i;

  always_comb begin
    gt_d  = gt_q;
    key_d = key_q;
    if (ctrl_i.cmp_en) begin
      gt_d = valid && ($signed(key_q) > $signed(op_key_i));
    end
    if (ctrl_i.ins_en && !gt_q) begin
      key_d = left_gt_i ? op_key_i : left_key_i;
    end else if (ctrl_i.rem_en && (IdxC >= rank_i)) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= 1'b0;
    end else begin
      gt_q <= gt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign gt_o  = gt_q;

endmodule

@@ rtl/ranked_sorted_set.sv @@
// Top level of the ranked sorted set: sequencer, chain of rss_cell slots,
// rank encoder and result register. Depends on rss_pkg and rss_cell.
//
// Usage: keys arrive on the input channel (in_valid_i / in_ready_o, payload
// in_beat_i). An insert beat stores its key in descending order and yields
// one result beat on the output channel (out_valid_o / out_ready_i, payload
// out_beat_o) carrying the count of stored keys strictly greater than it;
// an insert into a full store changes nothing and returns rejected set. A
// remove beat deletes the key at the given rank and yields no result; a
// rank at or beyond the stored count is dropped.
// Timing: in the cycle after acceptance every cell compares its key with the
// operand in parallel; in the next cycle the cells shift and the rank is
// encoded from the compare row into the result register. The next item is
// accepted in the cycle its predecessor applies.
// A stalled receiver holds the result register; a following remove still
// proceeds, while a following insert waits in its apply cycle until the
// result slot frees. Reset empties the store at once; no clearing pass.
module ranked_sorted_set
  import rss_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = (KEY_BITS > 32) ? KEY_BITS : 32;
  localparam int RW    = (CNT_W > 6) ? CNT_W : 6;
  localparam int PW    = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    StIdle,
    StCmp,
    StApply
  } state_e;

  state_e           state_q;
  in_beat_t         op_q;
  logic [CNT_W-1:0] count_q;
  logic             out_valid_q;
  out_beat_t        out_q;

  cell_ctrl_t            ctrl;
  logic [EXT_W-1:0]      key_ext;
  logic [KEY_BITS-1:0]   op_key;
  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [CAPACITY-1:0]   gt_vec;
  logic [CAPACITY:0]     gt_hi, gt_lo;
  logic [CNT_W-1:0]      pos;
  logic [PW-1:0]         pos_ext;
  logic                  full, rank_ok, apply_go, in_acc, is_ins;
  logic [CNT_W-1:0]      cell_rank;

  assign key_ext   = EXT_W'($signed(op_q.key));
  assign op_key    = key_ext[KEY_BITS-1:0];
  assign full      = count_q == CapC;
  assign rank_ok   = RW'(op_q.rank) < RW'(count_q);
  assign cell_rank = CNT_W'(op_q.rank);
  assign is_ins    = op_q.cmd == CmdInsert;
  assign apply_go  = (state_q == StApply) && (!is_ins || !out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == StIdle) || apply_go;
  assign in_acc    = in_valid_i && in_ready_o;

  always_comb begin
    ctrl.cmp_en = state_q == StCmp;
    ctrl.ins_en = apply_go && is_ins && !full;
    ctrl.rem_en = apply_go && !is_ins && rank_ok;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_BITS-1:0] left_key, right_key;
    logic                left_gt;
    if (g == 0) begin : g_first
      assign left_key = op_key;
      assign left_gt  = 1'b1;
    end else begin : g_mid
      assign left_key = cell_key[g-1];
      assign left_gt  = gt_vec[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[g];
    end else begin : g_inner
      assign right_key = cell_key[g+1];
    end
    rss_cell #(
      .CNT_W   (CNT_W),
      .KEY_BITS(KEY_BITS),
      .INDEX   (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .count_i    (count_q),
      .rank_i     (cell_rank),
      .op_key_i   (op_key),
      .left_key_i (left_key),
      .left_gt_i  (left_gt),
      .right_key_i(right_key),
      .key_o      (cell_key[g]),
      .gt_o       (gt_vec[g])
    );
  end

  assign gt_hi = {1'b0, gt_vec};
  assign gt_lo = {gt_vec, 1'b1};

  always_comb begin
    pos = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (gt_lo[i] && !gt_hi[i]) begin
        pos = pos | CNT_W'(i);
      end
    end
  end

  assign pos_ext = PW'(pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= StCmp;
          end
        end
        StCmp: begin
          state_q <= StApply;
        end
        StApply: begin
          if (apply_go) begin
            state_q <= in_acc ? StCmp : StIdle;
            if (is_ins) begin
              out_valid_q <= 1'b1;
              if (full) begin
                out_q.position <= '0;
                out_q.rejected <= 1'b1;
              end else begin
                out_q.position <= pos_ext[6:0];
                out_q.rejected <= 1'b0;
                count_q        <= count_q + CNT_W'(1);
              end
            end else if (rank_ok) begin
              count_q <= count_q - CNT_W'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= in_beat_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("entry count exceeds capacity");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_en |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the store");

  a_rem_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rem_en |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("remove did not shrink the store");

  a_gt_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StApply) |-> ((gt_vec & (gt_vec + CAPACITY'(1))) == '0))
    else $error("compare row is not a thermometer code");

  a_ins_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply_go && is_ins) |=> out_valid_q)
    else $error("insert produced no result");

endmodule
